[rtl/wbs_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted branch selector package
// Shared widths, the edge write bundle and the token that travels the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package wbs_pkg;

  localparam int NUM_EDGES = 64;
  localparam int EDGE_W    = 6;
  localparam int NODE_W    = 6;
  localparam int WEIGHT_W  = 16;
  localparam int ROLL_W    = 16;
  localparam int SUM_W     = WEIGHT_W + EDGE_W;
  localparam int CNT_W     = EDGE_W + 1;

  typedef struct packed {
    logic                en;
    logic [EDGE_W-1:0]   idx;
    logic [NODE_W-1:0]   node;
    logic                present;
    logic [WEIGHT_W-1:0] weight;
  } wr_t;

  typedef struct packed {
    logic              vld;
    logic              pass2;
    logic [NODE_W-1:0] node;
    logic [SUM_W-1:0]  acc;
    logic [CNT_W-1:0]  cnt;
    logic              zero;
    logic [SUM_W-1:0]  target;
    logic [CNT_W-1:0]  k;
    logic              hit;
    logic [EDGE_W-1:0] chosen;
    logic [EDGE_W-1:0] last;
  } tok_t;

endpackage

`default_nettype wire

[rtl/wbs_cell.sv]
// ----------------------------------------------------------------------------
// Weighted branch selector cell
// Holds one edge entry and updates the passing token by one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [wbs_pkg::EDGE_W-1:0] cell_idx,
  input  wire wbs_pkg::wr_t               wr,
  input  wire wbs_pkg::tok_t              tok_in,
  output wbs_pkg::tok_t                   tok_out
);

  logic                         present;
  logic [wbs_pkg::NODE_W-1:0]   source;
  logic [wbs_pkg::WEIGHT_W-1:0] weight;
  logic                         match;
  logic                         hit;
  logic [wbs_pkg::SUM_W-1:0]    acc_sum;
  wbs_pkg::tok_t                tok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
    end else if (wr.en && wr.idx == cell_idx) begin
      present <= wr.present;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == cell_idx) begin
      source <= wr.node;
      weight <= wr.weight;
    end
  end

  assign match   = tok_in.vld && present && (source == tok_in.node);
  assign acc_sum = tok_in.acc + {{(wbs_pkg::SUM_W - wbs_pkg::WEIGHT_W){1'b0}}, weight};
  assign hit     = tok_in.zero ? (tok_in.cnt == tok_in.k) : (tok_in.target <= acc_sum);

  always_comb begin
    tok_next = tok_in;
    if (match) begin
      tok_next.acc  = acc_sum;
      tok_next.cnt  = tok_in.cnt + 1'b1;
      tok_next.last = cell_idx;
      if (tok_in.pass2 && hit && !tok_in.hit) begin
        tok_next.hit    = 1'b1;
        tok_next.chosen = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

[rtl/wbs_ctrl.sv]
// ----------------------------------------------------------------------------
// Weighted branch selector controller
// Accepts items, launches the two tokens and forms the selection result.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         action,
  input  wire logic [wbs_pkg::EDGE_W-1:0]   edge_index,
  input  wire logic [wbs_pkg::NODE_W-1:0]   node,
  input  wire logic                         entry_valid,
  input  wire logic [wbs_pkg::WEIGHT_W-1:0] weight,
  input  wire logic [wbs_pkg::ROLL_W-1:0]   roll,
  input  wire wbs_pkg::tok_t                tok_tail,
  output wbs_pkg::wr_t                      wr,
  output wbs_pkg::tok_t                     tok_head,
  output logic                              busy,
  output logic                              done,
  output logic [wbs_pkg::EDGE_W-1:0]        chosen_edge,
  output logic                              found
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PASS1  = 5'b00010,
    S_MUL    = 5'b00100,
    S_LAUNCH = 5'b01000,
    S_PASS2  = 5'b10000
  } state_t;

  localparam int PW_W = wbs_pkg::ROLL_W + wbs_pkg::SUM_W;
  localparam int PK_W = wbs_pkg::ROLL_W + wbs_pkg::CNT_W;

  state_t                      state;
  state_t                      state_next;
  logic [wbs_pkg::NODE_W-1:0]  sel_node;
  logic [wbs_pkg::ROLL_W-1:0]  sel_roll;
  logic [wbs_pkg::SUM_W-1:0]   total;
  logic [wbs_pkg::CNT_W-1:0]   count;
  logic [PW_W-1:0]             prod_w;
  logic [PK_W-1:0]             prod_k;
  logic [wbs_pkg::SUM_W-1:0]   target;
  logic                        accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign wr.en      = accept && !action;
  assign wr.idx     = edge_index;
  assign wr.node    = node;
  assign wr.present = entry_valid;
  assign wr.weight  = weight;

  assign target = prod_w[PW_W-1:wbs_pkg::ROLL_W]
                + {{(wbs_pkg::SUM_W-1){1'b0}}, (prod_w[wbs_pkg::ROLL_W-1:0] != '0)};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && action) begin
          state_next = S_PASS1;
        end
      end
      S_PASS1: begin
        if (tok_tail.vld) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_LAUNCH;
      end
      S_LAUNCH: begin
        state_next = S_PASS2;
      end
      S_PASS2: begin
        if (tok_tail.vld) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      tok_head <= '0;
    end else begin
      state           <= state_next;
      done            <= (state == S_PASS2) && tok_tail.vld;
      tok_head.vld    <= (state == S_IDLE && accept && action) || (state == S_LAUNCH);
      tok_head.pass2  <= (state == S_LAUNCH);
      tok_head.node   <= (state == S_IDLE) ? node : sel_node;
      tok_head.acc    <= '0;
      tok_head.cnt    <= '0;
      tok_head.zero   <= (total == '0);
      tok_head.target <= target;
      tok_head.k      <= prod_k[PK_W-1:wbs_pkg::ROLL_W];
      tok_head.hit    <= 1'b0;
      tok_head.chosen <= '0;
      tok_head.last   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && action) begin
      sel_node <= node;
      sel_roll <= roll;
    end
    if (state == S_PASS1 && tok_tail.vld) begin
      total <= tok_tail.acc;
      count <= tok_tail.cnt;
    end
    if (state == S_MUL) begin
      prod_w <= PW_W'(sel_roll) * PW_W'(total);
      prod_k <= PK_W'(sel_roll) * PK_W'(count);
    end
    if (state == S_PASS2 && tok_tail.vld) begin
      found       <= (tok_tail.cnt != '0);
      chosen_edge <= (tok_tail.cnt == '0) ? '0 :
                     (tok_tail.hit ? tok_tail.chosen : tok_tail.last);
    end
  end

endmodule

`default_nettype wire

[rtl/weighted_branch_selector.sv]
// ----------------------------------------------------------------------------
// Weighted branch selector
// Roulette wheel selection over a table of weighted edges held in a row of cells.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low. With action low the
// item writes one edge entry in that cycle and busy stays low, so writes can be
// issued back to back. With action high the item selects a branch leaving the
// given node: a token walks the 64 cells once to total the weights and count
// the outgoing edges, the scaled target is formed by one multiply stage, and a
// second token walks the cells to pick the edge. The result appears on
// chosen_edge and found, marked by done high for exactly one cycle, and the
// next item can be accepted in that same cycle. The token walks the cell row
// one cell per cycle per pass. The receiver cannot stall the block and must
// take each result in its done cycle. Reset clears every present mark and any
// token in flight; source and weight are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_branch_selector (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [5:0]  edge_index,
  input  wire logic [5:0]  node,
  input  wire logic        entry_valid,
  input  wire logic [15:0] weight,
  input  wire logic [15:0] roll,
  output logic             done,
  output logic [5:0]       chosen_edge,
  output logic             found
);

  wbs_pkg::wr_t  wr;
  wbs_pkg::tok_t tok [wbs_pkg::NUM_EDGES+1];

  wbs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action      (action),
    .edge_index  (edge_index),
    .node        (node),
    .entry_valid (entry_valid),
    .weight      (weight),
    .roll        (roll),
    .tok_tail    (tok[wbs_pkg::NUM_EDGES]),
    .wr          (wr),
    .tok_head    (tok[0]),
    .busy        (busy),
    .done        (done),
    .chosen_edge (chosen_edge),
    .found       (found)
  );

  for (genvar i = 0; i < wbs_pkg::NUM_EDGES; i++) begin : g_cell
    wbs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (wbs_pkg::EDGE_W'(i)),
      .wr       (wr),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

endmodule

`default_nettype wire

[sim/tb_weighted_branch_selector.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted branch selector testbench
// Drives edge writes and branch selects through the start/busy handshake and
// checks every done strobe against an in-bench roulette wheel predictor. The
// predictor keeps its own edge table and works out each pick when the select
// item is accepted. Directed items cover empty nodes, zero total weight,
// removal and weight and roll extremes. Random items mostly build fans of
// edges on a few hub nodes and then select from them.
// ----------------------------------------------------------------------------

module tb_weighted_branch_selector;

  localparam int NUM_EDGES = wbs_pkg::NUM_EDGES;
  localparam int EDGE_W    = wbs_pkg::EDGE_W;
  localparam int NODE_W    = wbs_pkg::NODE_W;
  localparam int WEIGHT_W  = wbs_pkg::WEIGHT_W;
  localparam int ROLL_W    = wbs_pkg::ROLL_W;
  localparam int SUM_W     = wbs_pkg::SUM_W;
  localparam int CNT_W     = wbs_pkg::CNT_W;

  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_A = 20;
  localparam int HOLD_B = 380;
  localparam int CALM_TAIL = 100;
  localparam int DRAIN_CYCLES = 140;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 40;

  typedef enum logic {ACT_WRITE = 1'b0, ACT_SELECT = 1'b1} branch_action_t;

  typedef struct packed {
    branch_action_t      act;
    logic [EDGE_W-1:0]   idx;
    logic [NODE_W-1:0]   nd;
    logic                present;
    logic [WEIGHT_W-1:0] wt;
    logic [ROLL_W-1:0]   rl;
    logic                hold;
  } branch_item_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_id;
    logic              hit;
  } pick_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                action = 1'b0;
  logic [EDGE_W-1:0]   edge_index = '0;
  logic [NODE_W-1:0]   node = '0;
  logic                entry_valid = 1'b0;
  logic [WEIGHT_W-1:0] weight = '0;
  logic [ROLL_W-1:0]   roll = '0;
  logic                busy;
  logic                done;
  logic [EDGE_W-1:0]   chosen_edge;
  logic                found;

  branch_item_t pending_items[$];
  pick_t        expected_picks[$];

  logic                edge_on   [NUM_EDGES];
  logic [NODE_W-1:0]   edge_src  [NUM_EDGES];
  logic [WEIGHT_W-1:0] edge_wt   [NUM_EDGES];

  int cycle_count = 0;
  int items_queued = 0;
  int items_accepted = 0;
  int writes_accepted = 0;
  int selects_accepted = 0;
  int picks_checked = 0;
  int picks_found = 0;
  int error_count = 0;
  int gap_left = 0;
  bit gap_waits_idle = 1'b0;

  weighted_branch_selector uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .edge_index(edge_index),
    .node(node),
    .entry_valid(entry_valid),
    .weight(weight),
    .roll(roll),
    .done(done),
    .chosen_edge(chosen_edge),
    .found(found)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  function automatic pick_t roulette_pick(input logic [NODE_W-1:0] nd,
                                          input logic [ROLL_W-1:0] rl);
    logic [SUM_W-1:0]        total;
    logic [SUM_W-1:0]        acc;
    logic [CNT_W-1:0]        count;
    logic [CNT_W-1:0]        k;
    logic [SUM_W+ROLL_W-1:0] prod;
    logic [SUM_W:0]          target;
    logic [EDGE_W-1:0]       last;
    bit                      picked;
    pick_t                   res;
    total = '0;
    acc = '0;
    count = '0;
    last = '0;
    picked = 1'b0;
    res.edge_id = '0;
    res.hit = 1'b0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      if (edge_on[i] && edge_src[i] == nd) begin
        total = total + SUM_W'(edge_wt[i]);
        count = count + 1'b1;
        last = EDGE_W'(i);
      end
    end
    if (count != 0) begin
      res.hit = 1'b1;
      res.edge_id = last;
      if (total == 0) begin
        k = CNT_W'((32'(rl) * 32'(count)) >> ROLL_W);
        if (k >= count) k = count - 1'b1;
        for (int i = 0; i < NUM_EDGES; i++) begin
          if (!picked && edge_on[i] && edge_src[i] == nd) begin
            if (k == 0) begin
              res.edge_id = EDGE_W'(i);
              picked = 1'b1;
            end else begin
              k = k - 1'b1;
            end
          end
        end
      end else begin
        prod = (SUM_W+ROLL_W)'(rl) * (SUM_W+ROLL_W)'(total);
        target = (SUM_W+1)'(prod >> ROLL_W) + (SUM_W+1)'(prod[ROLL_W-1:0] != 0);
        for (int i = 0; i < NUM_EDGES; i++) begin
          if (!picked && edge_on[i] && edge_src[i] == nd) begin
            acc = acc + SUM_W'(edge_wt[i]);
            if (target <= (SUM_W+1)'(acc)) begin
              res.edge_id = EDGE_W'(i);
              picked = 1'b1;
            end
          end
        end
      end
    end
    return res;
  endfunction

  task automatic queue_write(input logic [EDGE_W-1:0] idx, input logic [NODE_W-1:0] nd,
                             input logic present, input logic [WEIGHT_W-1:0] wt);
    branch_item_t it;
    it.act = ACT_WRITE;
    it.idx = idx;
    it.nd = nd;
    it.present = present;
    it.wt = wt;
    it.rl = ROLL_W'($urandom);
    it.hold = (items_queued == HOLD_A || items_queued == HOLD_B);
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  task automatic queue_select(input logic [NODE_W-1:0] nd, input logic [ROLL_W-1:0] rl);
    branch_item_t it;
    it.act = ACT_SELECT;
    it.idx = EDGE_W'($urandom);
    it.nd = nd;
    it.present = 1'($urandom);
    it.wt = WEIGHT_W'($urandom);
    it.rl = rl;
    it.hold = (items_queued == HOLD_A || items_queued == HOLD_B);
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return WEIGHT_W'($urandom_range(1, 255));
      2: return WEIGHT_W'($urandom_range(16'hFF00, 16'hFFFF));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [ROLL_W-1:0] pick_roll();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ROLL_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d picks outstanding.",
               cycle_count, expected_picks.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    branch_item_t cur;
    logic         slot_free;
    bit           idle_ok;
    if (rst) begin
      start <= 1'b0;
      action <= ACT_WRITE;
      edge_index <= '0;
      node <= '0;
      entry_valid <= 1'b0;
      weight <= '0;
      roll <= '0;
      gap_left = 0;
    end else begin
      slot_free = !(start && busy);
      if (start && !busy) begin
        items_accepted++;
        if (action == ACT_SELECT) begin
          selects_accepted++;
          expected_picks = {expected_picks, roulette_pick(node, roll)};
        end else begin
          writes_accepted++;
          edge_on[edge_index] = entry_valid;
          edge_src[edge_index] = node;
          edge_wt[edge_index] = weight;
        end
        idle_ok = (pending_items.size() > CALM_TAIL) && ((items_accepted / 40) % 3 != 2);
        if (idle_ok && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 6);
          gap_waits_idle = $urandom_range(0, 1);
        end
      end
      if (slot_free) begin
        if (gap_left > 0) begin
          if (!gap_waits_idle || !busy) gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].hold && expected_picks.size() > 0)) begin
          cur = pending_items.pop_front();
          start <= 1'b1;
          action <= cur.act;
          edge_index <= cur.idx;
          node <= cur.nd;
          entry_valid <= cur.present;
          weight <= cur.wt;
          roll <= cur.rl;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pick_t want;
    if (!rst && done === 1'b1) begin
      picks_checked++;
      if (found === 1'b1) picks_found++;
      if (expected_picks.size() == 0) begin
        flag_mismatch($sformatf("result with none expected: edge %0d found %0b",
                                chosen_edge, found));
      end else begin
        want = expected_picks.pop_front();
        if (found !== want.hit) begin
          flag_mismatch($sformatf("found is %0b, expected %0b", found, want.hit));
        end
        if (chosen_edge !== want.edge_id) begin
          flag_mismatch($sformatf("chosen_edge is %0d, expected %0d",
                                  chosen_edge, want.edge_id));
        end
      end
    end
  end

  initial begin
    logic [NODE_W-1:0] hubs[8];
    logic [NODE_W-1:0] hub;
    int                hub_sel;
    int                fan;
    int                picks;
    int                target_items;

    for (int i = 0; i < NUM_EDGES; i++) begin
      edge_on[i] = 1'b0;
      edge_src[i] = '0;
      edge_wt[i] = '0;
    end

    // Empty table, then three zero-weight edges on one node.
    queue_select(6'd0, '0);
    queue_write(6'd0, 6'd5, 1'b1, '0);
    queue_write(6'd1, 6'd5, 1'b1, '0);
    queue_write(6'd2, 6'd5, 1'b1, '0);
    queue_select(6'd5, '0);
    queue_select(6'd5, '1);
    queue_select(6'd5, 16'h5556);
    // Lightest and heaviest weights on the top node and top edges.
    queue_write(6'd62, 6'd63, 1'b1, 16'h0001);
    queue_write(6'd63, 6'd63, 1'b1, '1);
    queue_select(6'd63, '0);
    queue_select(6'd63, '1);
    queue_select(6'd63, 16'h0001);
    // Removal of edges.
    queue_write(6'd62, 6'd63, 1'b0, '0);
    queue_select(6'd63, '0);
    queue_write(6'd1, 6'd5, 1'b0, '0);
    queue_select(6'd5, '1);
    // Mixed zero and non-zero weights.
    queue_write(6'd0, 6'd5, 1'b1, 16'h0100);
    queue_select(6'd5, 16'h8000);
    queue_select(6'd5, '1);
    queue_write(6'd2, 6'd5, 1'b1, '1);
    queue_select(6'd42, pick_roll());
    queue_select(6'd5, '1);

    hubs[0] = '0;
    hubs[1] = '1;
    for (int i = 2; i < 8; i++) hubs[i] = NODE_W'($urandom);

    target_items = items_queued + RANDOM_ITEMS;
    while (items_queued < target_items) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_write(EDGE_W'($urandom), NODE_W'($urandom), 1'($urandom),
                      WEIGHT_W'($urandom));
        end else begin
          queue_select(NODE_W'($urandom), ROLL_W'($urandom));
        end
      end else begin
        hub_sel = $urandom_range(0, 7);
        hub = hubs[hub_sel];
        fan = $urandom_range(0, 4);
        picks = $urandom_range(1, 3);
        for (int j = 0; j < fan; j++) begin
          // The last hub only ever gets zero weights from these sequences.
          queue_write(EDGE_W'($urandom), hub, $urandom_range(0, 7) != 0,
                      (hub_sel == 7) ? '0 : pick_weight());
        end
        for (int j = 0; j < picks; j++) queue_select(hub, pick_roll());
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted < items_queued) @(posedge clk);
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d edge writes and %0d branch selects; %0d results checked, %0d found.",
             writes_accepted, selects_accepted, picks_checked, picks_found);
    $display("Mismatches counted: %0d.", error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
